/* rtl/nes_pal_pixel_composite_encoder_core_assert.svh */
// Assertion macros shared by the encoder modules.
`ifndef NES_PAL_PIXEL_COMPOSITE_ENCODER_CORE_ASSERT_SVH
`define NES_PAL_PIXEL_COMPOSITE_ENCODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define NPCE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("npce: property violated");
`define NPCE_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("npce: forbidden condition seen");
`else
`define NPCE_ASSERT(lbl, clk, rstn, prop)
`define NPCE_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* rtl/npce_pkg.sv */
`default_nettype none
package npce_pkg;

  localparam int LevelW  = 18;
  localparam int SumW    = 20;
  localparam int MagW    = 19;
  localparam int ProdW   = 27;
  localparam int MagicW  = 28;
  localparam int QuotW   = 21;
  localparam int DivShift = 34;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  // ceil(2^34 / 110); exact truncating division for dividends below 2^27.
  localparam logic [MagicW-1:0] DivMagic = 28'd156180629;

  localparam logic [7:0] WhiteGainReset = 8'd100;

  typedef enum logic [1:0] {
    REG_PEDESTAL     = 2'd0,
    REG_BLACK_OFFSET = 2'd1,
    REG_WHITE_GAIN   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic            blank;
    logic [3:0][3:0] idx;
  } item_t;

  function automatic logic signed [LevelW-1:0] level(input logic [3:0] idx);
    logic signed [LevelW-1:0] lv;
    unique case (idx)
      4'd0:    lv = -18'sd14336;
      4'd1:    lv = 18'sd0;
      4'd2:    lv = 18'sd34406;
      4'd3:    lv = 18'sd77413;
      4'd4:    lv = -18'sd20070;
      4'd5:    lv = -18'sd8028;
      4'd6:    lv = 18'sd19611;
      4'd7:    lv = 18'sd54189;
      4'd8:    lv = 18'sd45874;
      4'd9:    lv = 18'sd75693;
      4'd10:   lv = 18'sd110098;
      4'd11:   lv = 18'sd110098;
      4'd12:   lv = 18'sd26951;
      4'd13:   lv = 18'sd52181;
      4'd14:   lv = 18'sd81472;
      4'd15:   lv = 18'sd81472;
      default: lv = 18'sd0;
    endcase
    return lv;
  endfunction

endpackage
`default_nettype wire

/* rtl/npce_front.sv */
`default_nettype none
`include "nes_pal_pixel_composite_encoder_core_assert.svh"
module npce_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [8:0]    pixel_i,
  input  wire logic [2:0]    line_mod6_i,
  input  wire logic          line_start_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          full_i,
  output logic               push_o,
  output npce_pkg::item_t    item_o
);

  logic [3:0] phase_q, phase_d;
  logic       alt_q, alt_d;
  logic [3:0] phase_cur;
  logic       alt_cur;

  function automatic logic [2:0] emph_mask(input logic [2:0] sel);
    logic [2:0] m;
    unique case (sel)
      3'd0:    m = 3'b011;
      3'd1:    m = 3'b010;
      3'd2:    m = 3'b110;
      3'd3:    m = 3'b100;
      3'd4:    m = 3'b101;
      3'd5:    m = 3'b001;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    logic [4:0] base;
    logic [4:0] ph_ls;
    logic [3:0] hue;
    logic [3:0] mhue;
    logic [4:0] pk;
    logic [4:0] t;
    logic [4:0] tm;
    logic [3:0] sel;
    logic       v;
    logic       e;
    logic       l;
    logic [4:0] p3;

    base  = {1'b0, line_mod6_i, 1'b0} + (line_mod6_i[0] ? 5'd0 : 5'd6);
    ph_ls = (base >= 5'd12) ? base - 5'd12 : base;
    phase_cur = line_start_i ? ph_ls[3:0] : phase_q;
    alt_cur   = line_start_i ? line_mod6_i[0] : alt_q;

    hue = pixel_i[3:0];
    if (!alt_cur) begin
      mhue = hue;
    end else if (hue <= 4'd11) begin
      mhue = 4'd11 - hue;
    end else begin
      mhue = 4'(5'd23 - {1'b0, hue});
    end

    item_o.blank = (hue >= 4'd14);
    for (int k = 0; k < 4; k++) begin
      pk = {1'b0, phase_cur} + 5'(k);
      t  = {1'b0, mhue} + pk;
      if (t >= 5'd24) begin
        tm = t - 5'd24;
      end else if (t >= 5'd12) begin
        tm = t - 5'd12;
      end else begin
        tm = t;
      end
      v   = (tm < 5'd6);
      sel = pk[4:1];
      if (sel >= 4'd6) begin
        sel = sel - 4'd6;
      end
      e = |(pixel_i[8:6] & emph_mask(sel[2:0]));
      if (hue == 4'd0) begin
        l = 1'b1;
      end else if (hue == 4'd13) begin
        l = 1'b0;
      end else begin
        l = v;
      end
      item_o.idx[k] = {l, e, pixel_i[5:4]};
    end

    p3      = {1'b0, phase_cur} + 5'd3;
    phase_d = (p3 >= 5'd12) ? 4'(p3 - 5'd12) : p3[3:0];
    alt_d   = alt_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 4'd0;
      alt_q   <= 1'b0;
    end else if (push_o) begin
      phase_q <= phase_d;
      alt_q   <= alt_d;
    end
  end

  `NPCE_ASSERT_NEVER(a_phase_range, clk_i, rst_ni, phase_q >= 4'd12)
  `NPCE_ASSERT(a_alt_hold, clk_i, rst_ni, !(push_o && line_start_i) |=> $stable(alt_q))

endmodule
`default_nettype wire

/* rtl/npce_queue.sv */
`default_nettype none
`include "nes_pal_pixel_composite_encoder_core_assert.svh"
module npce_queue #(
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire npce_pkg::item_t  item_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output npce_pkg::item_t       item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  npce_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `NPCE_ASSERT_NEVER(a_cnt_over, clk_i, rst_ni, cnt_q > CntW'(Depth))
  `NPCE_ASSERT(a_cnt_up, clk_i, rst_ni, (push_i && !do_pop) |=> cnt_q == $past(cnt_q) + CntW'(1))

endmodule
`default_nettype wire

/* rtl/npce_back.sv */
`default_nettype none
module npce_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 pop_o,
  input  wire npce_pkg::item_t item_i,
  input  wire logic [7:0]      pedestal_i,
  input  wire logic [7:0]      black_offset_i,
  input  wire logic [7:0]      white_gain_i,
  output logic [7:0]           sample_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;
  logic signed [npce_pkg::SumW-1:0] sum_q, sum_d;
  logic [npce_pkg::ProdW-1:0] prod_q, prod_d;
  logic neg2_q, neg3_q;
  logic [npce_pkg::QuotW-1:0] quot_q, quot_d;
  logic [7:0] sample_q, sample_d;

  assign r4 = !v4_q || out_ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign pop_o = valid_i && r1;

  always_comb begin
    logic signed [npce_pkg::LevelW-1:0] lv;
    logic [npce_pkg::SumW-1:0] neg_sum;
    logic [npce_pkg::MagW-1:0] mag;
    logic [npce_pkg::ProdW+npce_pkg::MagicW-1:0] full;
    logic [npce_pkg::QuotW:0] scaled;

    sum_d = {{12{pedestal_i[7]}}, pedestal_i}
          + {{12{black_offset_i[7]}}, black_offset_i};
    for (int k = 0; k < 4; k++) begin
      lv = item_i.blank ? '0 : npce_pkg::level(item_i.idx[k]);
      sum_d = sum_d + {{2{lv[npce_pkg::LevelW-1]}}, lv};
    end

    neg_sum = -sum_q;
    mag     = sum_q[npce_pkg::SumW-1] ? neg_sum[npce_pkg::MagW-1:0]
                                      : sum_q[npce_pkg::MagW-1:0];
    prod_d  = npce_pkg::ProdW'(mag) * npce_pkg::ProdW'(white_gain_i);

    full   = (npce_pkg::ProdW + npce_pkg::MagicW)'(prod_q)
           * (npce_pkg::ProdW + npce_pkg::MagicW)'(npce_pkg::DivMagic);
    quot_d = full[npce_pkg::ProdW+npce_pkg::MagicW-1:npce_pkg::DivShift];

    scaled   = neg3_q ? -{1'b0, quot_q} : {1'b0, quot_q};
    sample_d = scaled[19:12];
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      sum_q <= sum_d;
    end
    if (r2 && v1_q) begin
      prod_q <= prod_d;
      neg2_q <= sum_q[npce_pkg::SumW-1];
    end
    if (r3 && v2_q) begin
      quot_q <= quot_d;
      neg3_q <= neg2_q;
    end
    if (r4 && v3_q) begin
      sample_q <= sample_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  assign sample_o    = sample_q;
  assign out_valid_o = v4_q;

endmodule
`default_nettype wire

/* rtl/nes_pal_pixel_composite_encoder_core.sv */
// Converts a stream of 9-bit palette pixels into signed 8-bit PAL composite samples, one sample
// per pixel. A new pixel can be transferred on every clock and a result leaves on every clock
// when the output side keeps ready high; each pixel passes through the queue and then the sum,
// product, quotient and sample registers. The front end tracks the color phase and alternate-line
// flag and classifies each pixel into four level-table indices; a small queue feeds the back end,
// a four-stage pipeline that sums the levels, multiplies by the white gain, divides by 110 with a
// reciprocal multiply and takes the final shift. Configuration registers sit at byte addresses 0,
// 4 and 8 and are meant to be written only while no pixel is in flight.
`default_nettype none
module nes_pal_pixel_composite_encoder_core #(
  parameter int QueueDepth = 2
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [npce_pkg::AddrW-1:0]  paddr,
  input  wire logic [npce_pkg::DataW-1:0]  pwdata,
  output logic [npce_pkg::DataW-1:0]       prdata,
  output logic                             pready,
  input  wire logic [8:0]                  pixel_i,
  input  wire logic [2:0]                  line_mod6_i,
  input  wire logic                        line_start_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  output logic [7:0]                       sample_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i
);

  logic [7:0] pedestal_q, black_offset_q, white_gain_q;
  logic       wr_en;
  npce_pkg::reg_idx_e reg_idx;

  logic            full, push, q_valid, pop;
  npce_pkg::item_t front_item, back_item;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = npce_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pedestal_q     <= 8'd0;
      black_offset_q <= 8'd0;
      white_gain_q   <= npce_pkg::WhiteGainReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        npce_pkg::REG_PEDESTAL:     pedestal_q     <= pwdata[7:0];
        npce_pkg::REG_BLACK_OFFSET: black_offset_q <= pwdata[7:0];
        npce_pkg::REG_WHITE_GAIN:   white_gain_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      npce_pkg::REG_PEDESTAL:     prdata = {24'd0, pedestal_q};
      npce_pkg::REG_BLACK_OFFSET: prdata = {24'd0, black_offset_q};
      npce_pkg::REG_WHITE_GAIN:   prdata = {24'd0, white_gain_q};
      default:                    prdata = '0;
    endcase
  end

  npce_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pixel_i      (pixel_i),
    .line_mod6_i  (line_mod6_i),
    .line_start_i (line_start_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .full_i       (full),
    .push_o       (push),
    .item_o       (front_item)
  );

  npce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (back_item)
  );

  npce_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .pop_o          (pop),
    .item_i         (back_item),
    .pedestal_i     (pedestal_q),
    .black_offset_i (black_offset_q),
    .white_gain_i   (white_gain_q),
    .sample_o       (sample_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

endmodule
`default_nettype wire
